/* rtl/core/fsgs_pkg.sv */
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types and constants of the falling sand grid sweep block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsgs_pkg;

  // Grid geometry.
  localparam int HEIGHT    = 64;
  localparam int WIDTH     = 64;
  localparam int ROW_W     = $clog2(HEIGHT);
  localparam int COL_W     = $clog2(WIDTH);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int GRID_DEPTH = HEIGHT * (1 << COL_W);

  // Item field widths.
  localparam int CMD_W     = 2;
  localparam int FROW_W    = 6;
  localparam int FCOL_W    = 6;
  localparam int COLOR_W   = 8;
  localparam int MOVES_W   = 13;
  localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

  // Configuration register widths.
  localparam int BO_W      = 7;
  localparam int TOP_W     = 6;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;

  // Register index, taken from paddr bit 2.
  localparam logic CFG_BOTTOM_OFFSET = 1'b0;
  localparam logic CFG_TOP_ROW       = 1'b1;

  // One grid cell.
  typedef struct packed {
    logic               active;
    logic [COLOR_W-1:0] color;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

endpackage

`default_nettype wire

/* rtl/core/fsgs_if.sv */
// ----------------------------------------------------------------------------
// fsgs_in_if / fsgs_out_if
// Valid/ready channels that carry command items in and result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsgs_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsgs_pkg::CMD_W-1:0]    command;
  logic [fsgs_pkg::FROW_W-1:0]   row;
  logic [fsgs_pkg::FCOL_W-1:0]   col;
  logic                          cell_active;
  logic [fsgs_pkg::COLOR_W-1:0]  cell_color;

  modport source (output valid, command, row, col, cell_active, cell_color,
                  input ready);
  modport sink   (input valid, command, row, col, cell_active, cell_color,
                  output ready);
endinterface

interface fsgs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_active;
  logic [fsgs_pkg::COLOR_W-1:0]  out_color;
  logic [fsgs_pkg::MOVES_W-1:0]  moves;

  modport source (output valid, out_active, out_color, moves, input ready);
  modport sink   (input valid, out_active, out_color, moves, output ready);
endinterface

`default_nettype wire

/* rtl/core/fsgs_grid_ram.sv */
// ----------------------------------------------------------------------------
// fsgs_grid_ram
// Simple dual-port RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsgs_grid_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/falling_sand_grid_sweep.sv */
// ----------------------------------------------------------------------------
// falling_sand_grid_sweep
// Falling sand cellular automaton over a grid held in one RAM. Commands write
// a cell, read a cell or run one in-place sweep of the grid.
// ----------------------------------------------------------------------------
// A write goes from the execute state to the result; a read first waits in a
// read-wait state for the registered RAM data. A sweep reads one cell at a time
// through the single RAM read port. One item is in work at a time; the next is
// taken in the cycle after the result leaves.
// Reset: a clearing pass writes every one of the 4096 cells to zero, one per
// cycle, before the first item is accepted; configuration writes go on meanwhile.
`default_nettype none

module falling_sand_grid_sweep (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  fsgs_in_if.sink                            in_i,
  fsgs_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fsgs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fsgs_pkg::PDATA_W-1:0]  pwdata,
  output      logic [fsgs_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready
);

  import fsgs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDWAIT, S_ROW, S_SRC, S_CHK_SRC, S_CHK_B,
    S_CHK_BR, S_CHK_BL, S_WR_DST, S_WR_SRC, S_NEXT, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [BO_W-1:0]    bo_q;
  logic [TOP_W-1:0]   top_q;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [ROW_W-1:0]   r_q, r_d;
  logic [COL_W-1:0]   c_q, c_d;
  logic [COL_W-1:0]   probe_c_q, probe_c_d;
  cell_t              wcell_q, wcell_d;
  cell_t              v_q, v_d;
  logic               out_active_q, out_active_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic [MOVES_W-1:0] moves_q, moves_d;

  // RAM port signals.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  cell_t              ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  cell_t              rd_cell;

  // Shared column adder and helper terms.
  logic [COL_W-1:0]   col_delta;
  logic [COL_W-1:0]   nb_col;
  logic [ROW_W-1:0]   below_row;
  logic [ROW_W-1:0]   start_row;
  logic               sweep_empty;
  logic               row_last;
  logic               col_last;
  logic               col_first;
  logic               in_grid;
  logic               cfg_wr;

  fsgs_grid_ram #(
    .DEPTH  (GRID_DEPTH),
    .DATA_W (CELL_W)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_cell = ram_rdata;

  // Configuration port: registers decoded by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      CFG_BOTTOM_OFFSET: prdata = PDATA_W'(bo_q);
      CFG_TOP_ROW:       prdata = PDATA_W'(top_q);
      default:           prdata = '0;
    endcase
  end

  // Geometry terms.
  assign nb_col    = c_q + col_delta;
  assign below_row = r_q + ROW_W'(1);
  assign col_last  = (32'(c_q) == WIDTH - 1);
  assign col_first = (c_q == '0);
  assign row_last  = (r_q == '0) || (32'(r_q) <= 32'(top_q));
  assign in_grid   = (32'(r_q) < HEIGHT) && (32'(c_q) < WIDTH);

  // Start row: HEIGHT minus the offset, with an offset of zero saturating.
  assign start_row   = (bo_q == '0) ? ROW_W'(HEIGHT - 1)
                                    : ROW_W'(32'(HEIGHT) - 32'(bo_q));
  assign sweep_empty = (32'(bo_q) > HEIGHT) || (32'(start_row) < 32'(top_q));

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cmd_d        = cmd_q;
    r_d          = r_q;
    c_d          = c_q;
    probe_c_d    = probe_c_q;
    wcell_d      = wcell_q;
    v_d          = v_q;
    out_active_d = out_active_q;
    out_color_d  = out_color_q;
    moves_d      = moves_q;
    col_delta    = '0;
    ram_we       = 1'b0;
    ram_waddr    = {r_q, c_q};
    ram_wdata    = '0;
    ram_raddr    = {r_q, c_q};

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (32'(clr_q) == GRID_DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d          = in_i.command;
          r_d            = ROW_W'(in_i.row);
          c_d            = COL_W'(in_i.col);
          wcell_d.active = in_i.cell_active;
          wcell_d.color  = in_i.cell_color;
          out_active_d   = 1'b0;
          out_color_d    = '0;
          moves_d        = '0;
          state_d        = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_q)
          CMD_WRITE: begin
            ram_we    = in_grid;
            ram_wdata = wcell_q;
            state_d   = S_DONE;
          end
          CMD_READ: begin
            state_d = S_RDWAIT;
          end
          CMD_SWEEP: begin
            if (sweep_empty) begin
              state_d = S_DONE;
            end else begin
              r_d     = start_row;
              state_d = S_ROW;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_RDWAIT: begin
        if (in_grid) begin
          out_active_d = rd_cell.active;
          out_color_d  = rd_cell.color;
        end
        state_d = S_DONE;
      end

      // Row entry: the bottom row has nothing below and is skipped.
      S_ROW: begin
        if (32'(r_q) == HEIGHT - 1) begin
          if (row_last) begin
            state_d = S_DONE;
          end else begin
            r_d = r_q - ROW_W'(1);
          end
        end else begin
          c_d     = '0;
          state_d = S_SRC;
        end
      end

      S_SRC: begin
        state_d = S_CHK_SRC;
      end

      // Source cell arrives; probe straight below.
      S_CHK_SRC: begin
        v_d       = rd_cell;
        ram_raddr = {below_row, nb_col};
        probe_c_d = nb_col;
        state_d   = rd_cell.active ? S_CHK_B : S_NEXT;
      end

      S_CHK_B: begin
        if (!rd_cell.active) begin
          state_d = S_WR_DST;
        end else if (!col_last) begin
          col_delta = COL_W'(1);
          ram_raddr = {below_row, nb_col};
          probe_c_d = nb_col;
          state_d   = S_CHK_BR;
        end else if (!col_first) begin
          col_delta = '1;
          ram_raddr = {below_row, nb_col};
          probe_c_d = nb_col;
          state_d   = S_CHK_BL;
        end else begin
          state_d = S_NEXT;
        end
      end

      S_CHK_BR: begin
        if (!rd_cell.active) begin
          state_d = S_WR_DST;
        end else if (!col_first) begin
          col_delta = '1;
          ram_raddr = {below_row, nb_col};
          probe_c_d = nb_col;
          state_d   = S_CHK_BL;
        end else begin
          state_d = S_NEXT;
        end
      end

      S_CHK_BL: begin
        state_d = rd_cell.active ? S_NEXT : S_WR_DST;
      end

      S_WR_DST: begin
        ram_we    = 1'b1;
        ram_waddr = {below_row, probe_c_q};
        ram_wdata = v_q;
        state_d   = S_WR_SRC;
      end

      S_WR_SRC: begin
        ram_we = 1'b1;
        if (moves_q != MOVES_MAX) begin
          moves_d = moves_q + MOVES_W'(1);
        end
        state_d = S_NEXT;
      end

      S_NEXT: begin
        if (col_last) begin
          if (row_last) begin
            state_d = S_DONE;
          end else begin
            r_d     = r_q - ROW_W'(1);
            state_d = S_ROW;
          end
        end else begin
          c_d     = c_q + COL_W'(1);
          state_d = S_SRC;
        end
      end

      S_DONE: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, clear counter and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      bo_q    <= BO_W'(1);
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_wr) begin
        case (paddr[2])
          CFG_BOTTOM_OFFSET: bo_q  <= pwdata[BO_W-1:0];
          CFG_TOP_ROW:       top_q <= pwdata[TOP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    r_q          <= r_d;
    c_q          <= c_d;
    probe_c_q    <= probe_c_d;
    wcell_q      <= wcell_d;
    v_q          <= v_d;
    out_active_q <= out_active_d;
    out_color_q  <= out_color_d;
    moves_q      <= moves_d;
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_DONE);
  assign out_o.out_active = out_active_q;
  assign out_o.out_color  = out_color_q;
  assign out_o.moves      = moves_q;

  // A new item is never taken while a result waits.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  // Only a sweep reports moves.
  a_moves_sweep_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && cmd_q != CMD_SWEEP) |-> (out_o.moves == '0))
    else $error("nonzero moves on a non-sweep result");

  // Clearing a source cell counts exactly one move, saturating.
  a_move_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_SRC) |=>
      (moves_q == $past(moves_q) + MOVES_W'(1)) || ($past(moves_q) == MOVES_MAX))
    else $error("move counter did not advance");

endmodule

`default_nettype wire
